/* rtl/core/smac_pkg.sv */
// ----------------------------------------------------------------------------
// smac_pkg
// Shared types, register indexes and the sequencer microprogram of the
// sliding-mode angle controller.
// ----------------------------------------------------------------------------
`default_nettype none

package smac_pkg;

    // Signed Q-format sample word.
    typedef logic signed [31:0] t_q32;

    localparam t_q32 S32_MAX = 32'sh7FFF_FFFF;
    localparam t_q32 S32_MIN = 32'sh8000_0000;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 31;
    localparam int GAIN_W     = 24;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_MODE     = 4'd0;
    localparam t_cfg_idx REG_C_GAIN   = 4'd1;
    localparam t_cfg_idx REG_K_GAIN   = 4'd2;
    localparam t_cfg_idx REG_J_GAIN   = 4'd3;
    localparam t_cfg_idx REG_SW_GAIN  = 4'd4;
    localparam t_cfg_idx REG_DEADBAND = 4'd5;
    localparam t_cfg_idx REG_C1_GAIN  = 4'd6;
    localparam t_cfg_idx REG_C2_GAIN  = 4'd7;

    // Multiplier operand selection for one step.
    typedef enum logic [2:0] {
        MOP_NONE,
        MOP_E,
        MOP_SUM_LO,
        MOP_SUM_HI,
        MOP_REL,
        MOP_SS,
        MOP_S,
        MOP_INNER
    } t_mop;

    // Register-file update for one step.
    typedef enum logic [3:0] {
        ALU_NONE,
        ALU_PREP,
        ALU_DIFF,
        ALU_S_INIT,
        ALU_S_ADD,
        ALU_IN_INIT,
        ALU_IN_SUB,
        ALU_DRIVE,
        ALU_DBOUT
    } t_alu;

    // Sequencing of the step counter.
    typedef enum logic [1:0] {
        CND_NEXT,
        CND_IF_DB,
        CND_IF_PLAIN,
        CND_DONE
    } t_cond;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_PREP     = 4'd0;
    localparam t_pc PC_DIFF     = 4'd1;
    localparam t_pc PC_MUL_E    = 4'd2;
    localparam t_pc PC_SURF     = 4'd3;
    localparam t_pc PC_SUM_HI   = 4'd4;
    localparam t_pc PC_SURF_ADD = 4'd5;
    localparam t_pc PC_MUL_REL  = 4'd6;
    localparam t_pc PC_MUL_SS   = 4'd7;
    localparam t_pc PC_MUL_S    = 4'd8;
    localparam t_pc PC_SUB_S    = 4'd9;
    localparam t_pc PC_MUL_J    = 4'd10;
    localparam t_pc PC_DRIVE    = 4'd11;
    localparam t_pc PC_DEAD     = 4'd12;

    // One control word of the microprogram.
    typedef struct packed {
        t_mop  mop;
        t_alu  alu;
        t_cond cond;
        t_pc   target;
    } t_cw;

    // Saturate a 34-bit signed value to the signed 32-bit range.
    function automatic t_q32 sat34(input logic signed [33:0] v);
        t_q32 r;
        if (v[33] != v[32] || v[32] != v[31]) begin
            r = v[33] ? S32_MIN : S32_MAX;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Microprogram ROM. The multiply issued in a step lands in the
    // accumulator, and the register update of the following step consumes it.
    function automatic t_cw ucode(input t_pc pc);
        t_cw cw;
        cw = '{mop: MOP_NONE, alu: ALU_NONE, cond: CND_NEXT, target: PC_PREP};
        case (pc)
            PC_PREP: begin
                cw.alu = ALU_PREP;
            end
            PC_DIFF: begin
                cw.alu = ALU_DIFF;
            end
            PC_MUL_E: begin
                cw.mop    = MOP_E;
                cw.cond   = CND_IF_DB;
                cw.target = PC_DEAD;
            end
            PC_SURF: begin
                cw.mop    = MOP_SUM_LO;
                cw.alu    = ALU_S_INIT;
                cw.cond   = CND_IF_PLAIN;
                cw.target = PC_MUL_REL;
            end
            PC_SUM_HI: begin
                cw.mop = MOP_SUM_HI;
            end
            PC_SURF_ADD: begin
                cw.alu = ALU_S_ADD;
            end
            PC_MUL_REL: begin
                cw.mop = MOP_REL;
            end
            PC_MUL_SS: begin
                cw.mop = MOP_SS;
                cw.alu = ALU_IN_INIT;
            end
            PC_MUL_S: begin
                cw.mop = MOP_S;
                cw.alu = ALU_IN_SUB;
            end
            PC_SUB_S: begin
                cw.alu = ALU_IN_SUB;
            end
            PC_MUL_J: begin
                cw.mop = MOP_INNER;
            end
            PC_DRIVE: begin
                cw.alu  = ALU_DRIVE;
                cw.cond = CND_DONE;
            end
            PC_DEAD: begin
                cw.alu  = ALU_DBOUT;
                cw.cond = CND_DONE;
            end
            default: begin
                cw.cond = CND_DONE;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/smac_in_if.sv */
// ----------------------------------------------------------------------------
// smac_in_if
// Sample channel: target angle, measured angle and measured rate.
// ----------------------------------------------------------------------------
`default_nettype none

interface smac_in_if;
    logic               valid;
    logic               ready;
    smac_pkg::t_q32     target_angle;
    smac_pkg::t_q32     measured_angle;
    smac_pkg::t_q32     measured_rate;

    modport source (
        output valid,
        output target_angle,
        output measured_angle,
        output measured_rate,
        input  ready
    );

    modport sink (
        input  valid,
        input  target_angle,
        input  measured_angle,
        input  measured_rate,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/smac_out_if.sv */
// ----------------------------------------------------------------------------
// smac_out_if
// Result channel: saturated drive and the deadband flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface smac_out_if;
    logic               valid;
    logic               ready;
    smac_pkg::t_q32     drive;
    logic               in_deadband;

    modport source (
        output valid,
        output drive,
        output in_deadband,
        input  ready
    );

    modport sink (
        input  valid,
        input  drive,
        input  in_deadband,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/sliding_mode_angle_controller.sv */
// ----------------------------------------------------------------------------
// sliding_mode_angle_controller
// Sliding-mode angle controller with boundary layer, run by a small
// microprogram over one shared 33x25 multiplier and a wide accumulator.
// ----------------------------------------------------------------------------
//
// Channel    Direction  Handshake      Payload
// i_sample   in         valid/ready    target_angle, measured_angle, measured_rate
// o_result   out        valid/ready    drive, in_deadband
// i_cfg_*    in         write enable   register index, write data
//
// After a transfer on i_sample the sequencer runs 10 steps in plain mode,
// 12 in integral mode and 4 when the error is inside the deadband; the
// next sample is taken in the cycle after the last step. The step count is set
// by the single shared multiplier, and the integral product uses it twice.
// The final step waits while the output register still holds an untaken
// result. Synchronous reset clears the configuration and the controller state.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_mode_angle_controller #(
    parameter int FRAC_BITS = 16,
    parameter int SUM_WIDTH = 48
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    smac_in_if.sink                             i_sample,
    smac_out_if.source                          o_result,
    input  wire                                 i_cfg_we,
    input  wire [smac_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [smac_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int AW   = SUM_WIDTH + 25;
    localparam int SW1  = SUM_WIDTH + 1;
    localparam int HI_W = SUM_WIDTH - 32;
    localparam smac_pkg::t_q32 ONE     = 32'sd1 <<< FRAC_BITS;
    localparam smac_pkg::t_q32 NEG_ONE = -(32'sd1 <<< FRAC_BITS);
    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    // Configuration registers.
    logic                               r_mode;
    logic [smac_pkg::GAIN_W-1:0]        r_c_gain;
    logic [smac_pkg::GAIN_W-1:0]        r_k_gain;
    logic [smac_pkg::GAIN_W-1:0]        r_j_gain;
    logic [smac_pkg::GAIN_W-1:0]        r_sw_gain;
    logic [30:0]                        r_deadband;
    logic [smac_pkg::GAIN_W-1:0]        r_c1_gain;
    logic [smac_pkg::GAIN_W-1:0]        r_c2_gain;

    // Sequencer control.
    logic                               r_busy;
    logic                               n_busy;
    smac_pkg::t_pc                      r_pc;
    smac_pkg::t_pc                      n_pc;
    logic                               r_out_valid;
    logic                               n_out_valid;

    // Sample and controller state.
    smac_pkg::t_q32                     r_tgt;
    smac_pkg::t_q32                     r_ang;
    smac_pkg::t_q32                     r_rate;
    smac_pkg::t_q32                     r_prev_t;
    logic signed [32:0]                 r_prev_step;
    logic signed [SUM_WIDTH-1:0]        r_sum;

    // Working registers.
    logic signed [32:0]                 r_e;
    logic signed [32:0]                 r_step;
    smac_pkg::t_q32                     r_ddref;
    smac_pkg::t_q32                     r_rel;
    smac_pkg::t_q32                     r_s;
    smac_pkg::t_q32                     r_inner;
    logic                               r_in_db;
    logic signed [AW-1:0]               r_acc;

    // Output register.
    smac_pkg::t_q32                     r_drive;
    logic                               r_out_db;

    // Combinational signals.
    smac_pkg::t_cw                      w_cw;
    logic                               w_in_xfer;
    logic                               w_out_free;
    logic                               w_exec;
    logic signed [32:0]                 w_mul_a;
    logic [smac_pkg::GAIN_W-1:0]        w_mul_g;
    logic signed [57:0]                 w_prod;
    logic signed [AW-1:0]               w_shr;
    logic [AW-32:0]                     w_shr_top;
    smac_pkg::t_q32                     w_mq;
    smac_pkg::t_q32                     w_ss;
    logic signed [SW1-1:0]              w_sum_ext;
    logic signed [SUM_WIDTH-1:0]        w_sum_next;
    logic signed [32:0]                 w_mag;
    logic                               w_fin_drive;

    assign w_cw       = smac_pkg::ucode(r_pc);
    assign w_in_xfer  = i_sample.valid && !r_busy;
    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_exec     = r_busy && !(w_cw.cond == smac_pkg::CND_DONE && !w_out_free);
    assign w_fin_drive = w_exec && (w_cw.alu == smac_pkg::ALU_DRIVE);

    assign i_sample.ready       = !r_busy;
    assign o_result.valid       = r_out_valid;
    assign o_result.drive       = r_drive;
    assign o_result.in_deadband = r_out_db;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_c_gain   <= '0;
            r_k_gain   <= '0;
            r_j_gain   <= '0;
            r_sw_gain  <= '0;
            r_deadband <= '0;
            r_c1_gain  <= '0;
            r_c2_gain  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                smac_pkg::REG_MODE:     r_mode     <= i_cfg_data[0];
                smac_pkg::REG_C_GAIN:   r_c_gain   <= i_cfg_data[smac_pkg::GAIN_W-1:0];
                smac_pkg::REG_K_GAIN:   r_k_gain   <= i_cfg_data[smac_pkg::GAIN_W-1:0];
                smac_pkg::REG_J_GAIN:   r_j_gain   <= i_cfg_data[smac_pkg::GAIN_W-1:0];
                smac_pkg::REG_SW_GAIN:  r_sw_gain  <= i_cfg_data[smac_pkg::GAIN_W-1:0];
                smac_pkg::REG_DEADBAND: r_deadband <= i_cfg_data[30:0];
                smac_pkg::REG_C1_GAIN:  r_c1_gain  <= i_cfg_data[smac_pkg::GAIN_W-1:0];
                smac_pkg::REG_C2_GAIN:  r_c2_gain  <= i_cfg_data[smac_pkg::GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Step counter and busy flag.
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (!r_busy) begin
            if (w_in_xfer) begin
                n_busy = 1'b1;
                n_pc   = smac_pkg::PC_PREP;
            end
        end else if (w_exec) begin
            case (w_cw.cond)
                smac_pkg::CND_NEXT:     n_pc = r_pc + 1'b1;
                smac_pkg::CND_IF_DB:    n_pc = r_in_db ? w_cw.target : r_pc + 1'b1;
                smac_pkg::CND_IF_PLAIN: n_pc = !r_mode ? w_cw.target : r_pc + 1'b1;
                smac_pkg::CND_DONE: begin
                    n_pc   = w_cw.target;
                    n_busy = 1'b0;
                end
                default:                n_pc = r_pc + 1'b1;
            endcase
        end
    end

    // The output register fills on the final step and empties on a transfer.
    always_comb begin
        if (r_busy && w_exec && w_cw.cond == smac_pkg::CND_DONE) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= smac_pkg::PC_PREP;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    // Multiplier operand selection; gains are unsigned and zero-extended.
    always_comb begin
        w_mul_a = '0;
        w_mul_g = '0;
        case (w_cw.mop)
            smac_pkg::MOP_E: begin
                w_mul_a = r_e;
                w_mul_g = r_mode ? r_c1_gain : r_c_gain;
            end
            smac_pkg::MOP_SUM_LO: begin
                w_mul_a = {1'b0, r_sum[31:0]};
                w_mul_g = r_c2_gain;
            end
            smac_pkg::MOP_SUM_HI: begin
                w_mul_a = 33'($signed(r_sum[SUM_WIDTH-1 -: HI_W]));
                w_mul_g = r_c2_gain;
            end
            smac_pkg::MOP_REL: begin
                w_mul_a = 33'(r_rel);
                w_mul_g = r_c_gain;
            end
            smac_pkg::MOP_SS: begin
                w_mul_a = 33'(w_ss);
                w_mul_g = r_sw_gain;
            end
            smac_pkg::MOP_S: begin
                w_mul_a = 33'(r_s);
                w_mul_g = r_k_gain;
            end
            smac_pkg::MOP_INNER: begin
                w_mul_a = 33'(r_inner);
                w_mul_g = r_j_gain;
            end
            default: begin
            end
        endcase
    end

    assign w_prod = w_mul_a * $signed({1'b0, w_mul_g});

    // Scaled product: floor shift by the fraction width, then saturate.
    assign w_shr     = r_acc >>> FRAC_BITS;
    assign w_shr_top = w_shr[AW-1:31];
    always_comb begin
        if ((&w_shr_top) || !(|w_shr_top)) begin
            w_mq = w_shr[31:0];
        end else begin
            w_mq = w_shr[AW-1] ? smac_pkg::S32_MIN : smac_pkg::S32_MAX;
        end
    end

    // Boundary layer: surface clamped to plus or minus one.
    always_comb begin
        if (r_s > ONE) begin
            w_ss = ONE;
        end else if (r_s < NEG_ONE) begin
            w_ss = NEG_ONE;
        end else begin
            w_ss = r_s;
        end
    end

    // Saturating error integral and error magnitude.
    assign w_sum_ext = SW1'(r_sum) + SW1'(r_e);
    always_comb begin
        if (w_sum_ext[SW1-1] != w_sum_ext[SUM_WIDTH-1]) begin
            w_sum_next = w_sum_ext[SW1-1] ? SUM_MIN : SUM_MAX;
        end else begin
            w_sum_next = w_sum_ext[SUM_WIDTH-1:0];
        end
    end
    assign w_mag = r_e[32] ? -r_e : r_e;

    // Sample capture.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_tgt  <= i_sample.target_angle;
            r_ang  <= i_sample.measured_angle;
            r_rate <= i_sample.measured_rate;
        end
    end

    // Accumulator: load a product, or add the upper partial product.
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            case (w_cw.mop)
                smac_pkg::MOP_NONE: begin
                end
                smac_pkg::MOP_SUM_HI: begin
                    r_acc <= r_acc + (AW'(w_prod) <<< 32);
                end
                default: begin
                    r_acc <= AW'(w_prod);
                end
            endcase
        end
    end

    // Working register updates selected by the control word.
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            case (w_cw.alu)
                smac_pkg::ALU_PREP: begin
                    r_e    <= 33'(r_ang) - 33'(r_tgt);
                    r_step <= 33'(r_tgt) - 33'(r_prev_t);
                end
                smac_pkg::ALU_DIFF: begin
                    r_ddref <= smac_pkg::sat34(34'(r_step) - 34'(r_prev_step));
                    r_rel   <= smac_pkg::sat34(34'(r_rate) - 34'(r_step));
                    r_in_db <= $unsigned(w_mag) < {2'b00, r_deadband};
                end
                smac_pkg::ALU_S_INIT: begin
                    r_s <= smac_pkg::sat34(34'(w_mq) + 34'(r_rel));
                end
                smac_pkg::ALU_S_ADD: begin
                    r_s <= smac_pkg::sat34(34'(r_s) + 34'(w_mq));
                end
                smac_pkg::ALU_IN_INIT: begin
                    r_inner <= smac_pkg::sat34(34'(r_ddref) - 34'(w_mq));
                end
                smac_pkg::ALU_IN_SUB: begin
                    r_inner <= smac_pkg::sat34(34'(r_inner) - 34'(w_mq));
                end
                smac_pkg::ALU_DRIVE: begin
                    r_drive  <= w_mq;
                    r_out_db <= 1'b0;
                end
                smac_pkg::ALU_DBOUT: begin
                    r_drive  <= '0;
                    r_out_db <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Controller state carried from sample to sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_t    <= '0;
            r_prev_step <= '0;
            r_sum       <= '0;
        end else if (w_exec) begin
            if (w_cw.alu == smac_pkg::ALU_DIFF) begin
                r_prev_step <= r_step;
                if (r_mode) begin
                    r_sum <= w_sum_next;
                end
            end
            if (w_fin_drive) begin
                r_prev_t <= r_tgt;
            end
        end
    end

`ifndef SYNTHESIS
    // A deadband result always carries a zero drive.
    a_db_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.in_deadband |-> o_result.drive == '0)
        else $error("deadband result with nonzero drive");

    // The step counter stays inside the microprogram while a sample runs.
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_pc <= smac_pkg::PC_DEAD)
        else $error("step counter outside the microprogram");

    // Every accepted sample starts at the first step.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sample.valid && i_sample.ready |=> r_busy && r_pc == smac_pkg::PC_PREP)
        else $error("sample did not start the sequencer");

    // The last target moves only when a drive result is produced.
    a_prev_t: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_prev_t) |-> $past(w_fin_drive) || $past(!i_rst_n))
        else $error("last target changed outside a drive result");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking regression for the sliding-mode angle controller. Control
// samples are sent from a queue with random gaps while the result side stalls
// at random. Each accepted sample is run through a bit-exact model of the
// control law, and the model's drive and deadband flag are matched against
// the results in order. Directed corners come first, then random phases under
// changing gains, and finally a short random run under one more configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC          = 16;
    localparam int SUM_W         = 48;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int CYCLE_LIMIT   = 2_000_000;

    localparam smac_pkg::t_cfg_idx REG_SPARE = 4'd15;

    localparam logic signed [63:0] SUM_MAX = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SUM_MIN = -SUM_MAX - 64'sd1;
    localparam logic signed [63:0] UNIT    = 64'sd1 <<< FRAC;

    typedef logic [smac_pkg::CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [smac_pkg::GAIN_W-1:0]     t_gain;

    typedef struct packed {
        smac_pkg::t_q32 target;
        smac_pkg::t_q32 angle;
        smac_pkg::t_q32 rate;
    } t_angle_sample;

    typedef struct packed {
        smac_pkg::t_q32 drive;
        logic           dead;
    } t_drive_result;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [smac_pkg::CFG_IDX_W-1:0]     i_cfg_idx;
    logic [smac_pkg::CFG_DATA_W-1:0]    i_cfg_data;

    smac_in_if  sample_ch ();
    smac_out_if result_ch ();

    // Controller registers as the model sees them.
    logic                  cfg_integral;
    t_gain                 cfg_c, cfg_k, cfg_j, cfg_sw, cfg_c1, cfg_c2;
    logic [30:0]           cfg_deadband;

    // Controller state as the model sees it.
    smac_pkg::t_q32        prev_target;
    logic signed [32:0]    prev_step;
    logic signed [47:0]    err_sum;

    t_angle_sample         samples_pending[$];
    t_drive_result         drive_due[$];
    t_angle_sample         cur_sample;
    t_drive_result         due;
    smac_pkg::t_q32        trk_target;

    int                    send_gap, send_calm, take_stall, take_calm;
    int                    fails, cycles, random_sent, phase_len;

    sliding_mode_angle_controller #(
        .FRAC_BITS (FRAC),
        .SUM_WIDTH (SUM_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (sample_ch),
        .o_result   (result_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Clock and time-zero values of every block input.
    initial begin
        i_clk                    = 1'b0;
        i_rst_n                  = 1'b0;
        i_cfg_we                 = 1'b0;
        i_cfg_idx                = smac_pkg::REG_MODE;
        i_cfg_data               = '0;
        sample_ch.valid          = 1'b0;
        sample_ch.target_angle   = '0;
        sample_ch.measured_angle = '0;
        sample_ch.measured_rate  = '0;
        result_ch.ready          = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    // Saturate to the signed 32-bit range.
    function automatic smac_pkg::t_q32 sat_q32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return smac_pkg::S32_MAX;
        if (v < -64'sd2147483648) return smac_pkg::S32_MIN;
        return v[31:0];
    endfunction

    // Gain product: exact multiply, floor shift by the fraction, saturate.
    function automatic smac_pkg::t_q32 mul_q(input logic signed [63:0] a, input t_gain g);
        logic signed [95:0] prod;
        prod = a * $signed({1'b0, g});
        prod = prod >>> FRAC;
        return sat_q32(prod[63:0]);
    endfunction

    // Control law for one sample; advances the model state.
    function automatic t_drive_result predict_drive(input t_angle_sample x);
        logic signed [63:0] err, step, ddref, mag, rel, surf, bounded, inner, acc;
        t_drive_result r;
        err   = $signed(x.angle) - $signed(x.target);
        step  = $signed(x.target) - prev_target;
        ddref = sat_q32(step - prev_step);
        mag   = (err < 0) ? -err : err;
        prev_step = step[32:0];
        if (cfg_integral) begin
            acc = err_sum + err;
            if (acc > SUM_MAX) acc = SUM_MAX;
            else if (acc < SUM_MIN) acc = SUM_MIN;
            err_sum = acc[47:0];
        end
        // Inside the deadband the drive is forced to zero and the target is held.
        if (mag < $signed({33'd0, cfg_deadband})) begin
            r.drive = '0;
            r.dead  = 1'b1;
            return r;
        end
        rel = sat_q32($signed(x.rate) - step);
        if (cfg_integral) begin
            surf = sat_q32(sat_q32(mul_q(err, cfg_c1) + rel) + mul_q(err_sum, cfg_c2));
        end else begin
            surf = sat_q32(mul_q(err, cfg_c) + rel);
        end
        bounded = (surf > UNIT) ? UNIT : ((surf < -UNIT) ? -UNIT : surf);
        inner   = sat_q32(ddref - mul_q(rel, cfg_c));
        inner   = sat_q32(inner - mul_q(bounded, cfg_sw));
        inner   = sat_q32(inner - mul_q(surf, cfg_k));
        r.drive = mul_q(inner, cfg_j);
        r.dead  = 1'b0;
        prev_target = x.target;
        return r;
    endfunction

    // Idle cycles before the next item, with occasional runs of none at all.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    function automatic smac_pkg::t_q32 corner_value();
        case ($urandom_range(0, 6))
            0: return smac_pkg::S32_MIN;
            1: return smac_pkg::S32_MAX;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return 32'sd1;
            5: return smac_pkg::S32_MIN + 32'sd1;
            default: return smac_pkg::S32_MAX - 32'sd1;
        endcase
    endfunction

    // Gain word: the upper bits carry junk that the block must drop.
    function automatic t_cfg_data gain_word();
        t_cfg_data w;
        w = t_cfg_data'($urandom);
        case ($urandom_range(0, 9))
            0: w[smac_pkg::GAIN_W-1:0] = '0;
            1: w[smac_pkg::GAIN_W-1:0] = '1;
            2, 3: w[smac_pkg::GAIN_W-1:0] = t_gain'($urandom);
            default: w[smac_pkg::GAIN_W-1:0] = t_gain'($urandom_range(0, 1 << 18));
        endcase
        return w;
    endfunction

    // One register write; the model copy follows at once since the block is idle.
    task automatic write_reg(input smac_pkg::t_cfg_idx idx, input t_cfg_data data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            smac_pkg::REG_MODE:     cfg_integral = data[0];
            smac_pkg::REG_C_GAIN:   cfg_c        = data[smac_pkg::GAIN_W-1:0];
            smac_pkg::REG_K_GAIN:   cfg_k        = data[smac_pkg::GAIN_W-1:0];
            smac_pkg::REG_J_GAIN:   cfg_j        = data[smac_pkg::GAIN_W-1:0];
            smac_pkg::REG_SW_GAIN:  cfg_sw       = data[smac_pkg::GAIN_W-1:0];
            smac_pkg::REG_DEADBAND: cfg_deadband = data[30:0];
            smac_pkg::REG_C1_GAIN:  cfg_c1       = data[smac_pkg::GAIN_W-1:0];
            smac_pkg::REG_C2_GAIN:  cfg_c2       = data[smac_pkg::GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic cfg_port_idle();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_config();
        t_cfg_data db;
        db = t_cfg_data'($urandom);
        case ($urandom_range(0, 7))
            0: db = '0;
            1: db = '1;
            2: ;
            3, 4: db = t_cfg_data'($urandom_range(0, 1 << 20));
            default: db = t_cfg_data'($urandom_range(0, 1 << 14));
        endcase
        write_reg(smac_pkg::REG_MODE, t_cfg_data'($urandom));
        write_reg(smac_pkg::REG_C_GAIN, gain_word());
        write_reg(smac_pkg::REG_K_GAIN, gain_word());
        write_reg(smac_pkg::REG_J_GAIN, gain_word());
        write_reg(smac_pkg::REG_SW_GAIN, gain_word());
        write_reg(smac_pkg::REG_DEADBAND, db);
        write_reg(smac_pkg::REG_C1_GAIN, gain_word());
        write_reg(smac_pkg::REG_C2_GAIN, gain_word());
        if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, t_cfg_data'($urandom));
        cfg_port_idle();
    endtask

    task automatic push_sample(input smac_pkg::t_q32 t, input smac_pkg::t_q32 m,
                               input smac_pkg::t_q32 r);
        samples_pending.push_back('{target: t, angle: m, rate: r});
    endtask

    // Mostly a smooth target with a nearby measurement, some raw noise.
    task automatic push_random_sample();
        smac_pkg::t_q32 t, m, r;
        case ($urandom_range(0, 9))
            0: begin
                t = $urandom;
                m = $urandom;
                r = $urandom;
            end
            1: begin
                t = corner_value();
                m = corner_value();
                r = corner_value();
            end
            default: begin
                trk_target = trk_target + ($signed($urandom) >>> $urandom_range(10, 30));
                t = trk_target;
                m = t + ($signed($urandom) >>> $urandom_range(6, 31));
                r = $signed($urandom) >>> $urandom_range(2, 31);
            end
        endcase
        push_sample(t, m, r);
    endtask

    // Wait until every queued sample is sent and every result has come back.
    // The check is made at the falling edge, after the rising-edge updates settle.
    task automatic drain();
        while (samples_pending.size() != 0 || sample_ch.valid || drive_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Sample driver; the prediction is made at the edge of each transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sample_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (sample_ch.valid && sample_ch.ready) begin
                drive_due.push_back(predict_drive(cur_sample));
            end
            if (!sample_ch.valid || sample_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    sample_ch.valid <= 1'b0;
                end else if (samples_pending.size() > 0) begin
                    cur_sample = samples_pending.pop_front();
                    sample_ch.valid          <= 1'b1;
                    sample_ch.target_angle   <= cur_sample.target;
                    sample_ch.measured_angle <= cur_sample.angle;
                    sample_ch.measured_rate  <= cur_sample.rate;
                    send_gap = draw_wait(send_calm);
                end else begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transfer, then stalls for a random while.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            take_stall = 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (drive_due.size() == 0) begin
                    fails++;
                    $display("%0t ns: result with nothing expected: drive %0d in_deadband %0b",
                             $time, result_ch.drive, result_ch.in_deadband);
                end else begin
                    due = drive_due.pop_front();
                    if (result_ch.drive !== due.drive) begin
                        fails++;
                        $display("%0t ns: drive mismatch: expected %0d, actual %0d",
                                 $time, due.drive, result_ch.drive);
                    end
                    if (result_ch.in_deadband !== due.dead) begin
                        fails++;
                        $display("%0t ns: in_deadband mismatch: expected %0b, actual %0b",
                                 $time, due.dead, result_ch.in_deadband);
                    end
                end
                take_stall = draw_wait(take_calm);
            end
            if (take_stall > 0) begin
                take_stall--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("sliding_mode_angle_controller regression: fail");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        cfg_integral = 1'b0;
        cfg_c = '0; cfg_k = '0; cfg_j = '0; cfg_sw = '0; cfg_c1 = '0; cfg_c2 = '0;
        cfg_deadband = '0;
        prev_target = '0;
        prev_step   = '0;
        err_sum     = '0;
        trk_target  = '0;
        fails = 0; cycles = 0; random_sent = 0;
        send_calm = 0; take_calm = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: all gains zero, so the drive stays zero.
        push_sample(32'sd0, 32'sd0, 32'sd0);
        push_sample(smac_pkg::S32_MAX, smac_pkg::S32_MIN, smac_pkg::S32_MAX);
        push_sample(smac_pkg::S32_MIN, smac_pkg::S32_MAX, smac_pkg::S32_MIN);
        drain();

        // Plain surface, unit C and J gains, K of one half, SW of two and a small deadband.
        write_reg(smac_pkg::REG_MODE, 31'h0000_0000);
        write_reg(smac_pkg::REG_C_GAIN, 31'h0001_0000);
        write_reg(smac_pkg::REG_K_GAIN, 31'h0000_8000);
        write_reg(smac_pkg::REG_J_GAIN, 31'h0001_0000);
        write_reg(smac_pkg::REG_SW_GAIN, 31'h0002_0000);
        write_reg(smac_pkg::REG_DEADBAND, 31'h0000_0100);
        cfg_port_idle();
        // Zero error, the deadband edge from both sides and both signs.
        push_sample(32'sd1000, 32'sd1000, 32'sd0);
        push_sample(32'sd1000, 32'sd1256, 32'sd0);
        push_sample(32'sd1000, 32'sd1255, 32'sd0);
        push_sample(32'sd1000, 32'sd745, 32'sd0);
        push_sample(32'sd1000, 32'sd744, 32'sd5);
        // Full-scale target steps that saturate the step change.
        push_sample(smac_pkg::S32_MAX, smac_pkg::S32_MAX - 32'sh1_0000, 32'sh3_0000);
        push_sample(smac_pkg::S32_MIN, smac_pkg::S32_MIN + 32'sh2_0000, smac_pkg::S32_MIN);
        push_sample(smac_pkg::S32_MIN, smac_pkg::S32_MAX, smac_pkg::S32_MAX);
        push_sample(smac_pkg::S32_MAX, smac_pkg::S32_MIN, smac_pkg::S32_MIN);
        // Small errors; the second sample has its surface inside the boundary layer, so its switching term is linear.
        push_sample(32'sd0, 32'sh1000, 32'sd0);
        push_sample(32'sd0, 32'sh0800, 32'sh0400);
        drain();

        // Integral surface with every gain at full scale and no deadband.
        write_reg(smac_pkg::REG_MODE, 31'h7FFF_FFFF);
        write_reg(smac_pkg::REG_C_GAIN, 31'h7FFF_FFFF);
        write_reg(smac_pkg::REG_K_GAIN, 31'h7FFF_FFFF);
        write_reg(smac_pkg::REG_J_GAIN, 31'h7FFF_FFFF);
        write_reg(smac_pkg::REG_SW_GAIN, 31'h7FFF_FFFF);
        write_reg(smac_pkg::REG_DEADBAND, 31'h0000_0000);
        write_reg(smac_pkg::REG_C1_GAIN, 31'h7FFF_FFFF);
        write_reg(smac_pkg::REG_C2_GAIN, 31'h7FFF_FFFF);
        write_reg(REG_SPARE, 31'h7FFF_FFFF);
        cfg_port_idle();
        push_sample(32'sd0, 32'sd0, 32'sd0);
        push_sample(smac_pkg::S32_MIN, smac_pkg::S32_MAX, smac_pkg::S32_MAX);
        push_sample(smac_pkg::S32_MIN, smac_pkg::S32_MAX, smac_pkg::S32_MIN);
        push_sample(smac_pkg::S32_MAX, smac_pkg::S32_MIN, smac_pkg::S32_MAX);
        push_sample(smac_pkg::S32_MAX, smac_pkg::S32_MIN, smac_pkg::S32_MIN);
        push_sample(-32'sd1, 32'sd1, -32'sd1);
        drain();

        // Random phases, each under a fresh configuration.
        while (random_sent < RANDOM_ITEMS) begin
            random_config();
            phase_len = $urandom_range(120, 240);
            repeat (phase_len) push_random_sample();
            random_sent += phase_len;
            drain();
        end

        // A last short run under one more configuration.
        random_config();
        repeat (60) push_random_sample();
        drain();

        repeat (40) @(posedge i_clk);
        if (fails == 0) begin
            $display("sliding_mode_angle_controller regression: pass");
        end else begin
            $display("sliding_mode_angle_controller regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
